>>> hdl/stable_priority_request_queue_macros.svh
// Assertion macros shared by the queue RTL.
`ifndef STABLE_PRIORITY_REQUEST_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_REQUEST_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/spq_pkg.sv
package spq_pkg;

    localparam int PRIO_W = 8;
    localparam int TAG_W  = 16;
    localparam int OCC_W  = 5;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DEQUEUED = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } cmd_t;

endpackage

>>> hdl/spq_cell.sv
module spq_cell (
    input  logic           clk,
    input  spq_pkg::cmd_t  cmd,
    input  logic           valid,
    input  logic           left_valid,
    input  logic           left_gt,
    input  spq_pkg::entry_t left_entry,
    input  spq_pkg::entry_t right_entry,
    output spq_pkg::entry_t entry,
    output logic           gt
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // This cell holds a request that must move behind the new one.
    assign gt = valid && (cmd.prio < entry_reg.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.enq)
        begin
            if (left_gt)
            begin
                entry_next = left_entry;
            end
            else if (gt || (!valid && left_valid))
            begin
                entry_next.prio = cmd.prio;
                entry_next.tag  = cmd.tag;
            end
        end
        else if (cmd.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> hdl/stable_priority_request_queue.sv
// Channel   Handshake            Payload
// input     start, busy          kind, priority_req, request_tag
// result    done                 status, out_tag, out_priority, occupancy
//
// Busy stays low, so a new beat is taken in every cycle. The result
// appears in the cycle after its beat, with done high for a single
// cycle. Reset empties the queue by clearing the count; cell contents
// are left as they are. The receiver cannot stall.
module stable_priority_request_queue #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       kind,
    input  logic [spq_pkg::PRIO_W-1:0] priority_req,
    input  logic [spq_pkg::TAG_W-1:0]  request_tag,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [spq_pkg::TAG_W-1:0]  out_tag,
    output logic [spq_pkg::PRIO_W-1:0] out_priority,
    output logic [spq_pkg::OCC_W-1:0]  occupancy
);
    import spq_pkg::*;
    `include "stable_priority_request_queue_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              done_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [TAG_W-1:0]  tag_reg;
    logic [TAG_W-1:0]  tag_next;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic [OCC_W-1:0]  occ_reg;

    cmd_t   cmd;
    logic   accept;
    logic   full;
    logic   empty;
    entry_t cell_entry [DEPTH];
    logic   cell_gt    [DEPTH];
    logic   cell_valid [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);

    assign cmd.enq  = accept && !kind && !full;
    assign cmd.deq  = accept && kind && !empty;
    assign cmd.prio = priority_req;
    assign cmd.tag  = request_tag;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_entry;
        entry_t right_entry;
        logic   left_valid;
        logic   left_gt;

        assign cell_valid[i] = (count_reg > CW'(i));

        if (i == 0)
        begin : g_head
            assign left_entry = '0;
            assign left_valid = 1'b1;
            assign left_gt    = 1'b0;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .valid       (cell_valid[i]),
            .left_valid  (left_valid),
            .left_gt     (left_gt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_ENQUEUED;
        tag_next    = '0;
        prio_next   = '0;
        if (!kind)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else if (empty)
        begin
            status_next = ST_EMPTY;
        end
        else
        begin
            status_next = ST_DEQUEUED;
            tag_next    = cell_entry[0].tag;
            prio_next   = cell_entry[0].prio;
            count_next  = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            tag_reg    <= tag_next;
            prio_reg   <= prio_next;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_tag      = tag_reg;
    assign out_priority = prio_reg;
    assign occupancy    = occ_reg;

    `SPQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH),
        "entry count exceeds depth")
    `SPQ_ASSERT_NEXT(a_done_follows, clk, rst_n, accept, done_reg,
        "accepted beat gave no result")
    `SPQ_ASSERT_NEXT(a_enq_count, clk, rst_n, cmd.enq,
        count_reg == $past(count_reg) + CW'(1), "enqueue did not grow the count")
    `SPQ_ASSERT_SAME(a_head_order, clk, rst_n, cell_valid[1],
        cell_entry[0].prio <= cell_entry[1].prio, "front cells out of order")

endmodule
